// File: rtl/scaled_fixed_step_timebase_core_assert.svh
// ----------------------------------------------------------------------------
// scaled fixed-step timebase assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCALED_FIXED_STEP_TIMEBASE_CORE_ASSERT_SVH
`define SCALED_FIXED_STEP_TIMEBASE_CORE_ASSERT_SVH

// same-cycle implication
`define SFST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfst_pkg.sv
// ----------------------------------------------------------------------------
// sfst_pkg
// shared widths, register indexes, clamp limits and item types of the timebase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfst_pkg;

  localparam int MAX_STEPS_DEF = 8;

  localparam int REAL_W     = 36;
  localparam int SCALE_W    = 27;
  localparam int STEP_W     = 33;
  localparam int TIME_W     = 64;
  localparam int LEN_W      = 48;
  localparam int HALF_W     = 18;
  localparam int PP_W       = HALF_W + 1 + SCALE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  localparam logic [CFG_IDX_W-1:0] REG_PAUSED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP = 3'd4;

  localparam logic signed [SCALE_W-1:0] SCALE_LIMIT = 27'sd65536000;
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 27'sd65536;
  localparam logic [STEP_W-1:0] STEP_MIN   = 33'd17895697;
  localparam logic [STEP_W-1:0] STEP_MAX   = 33'h1_0000_0000;
  localparam logic [STEP_W-1:0] STEP_RESET = 33'd71582788;

  localparam logic [1:0] KIND_HOLD  = 2'd0;
  localparam logic [1:0] KIND_REAL  = 2'd1;
  localparam logic [1:0] KIND_FIXED = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [LEN_W-1:0] delta;
  } item_t;

  typedef struct packed {
    logic [STEP_W-1:0] fixed_step;
    logic              acc_clr;
  } back_cfg_t;

endpackage

`default_nettype wire

// File: rtl/scaled_fixed_step_timebase_core.sv
// ----------------------------------------------------------------------------
// scaled_fixed_step_timebase_core
// path: front stage register, then queue, then back end and output register;
//   a fixed-mode item enters ST_STEP first, then gives one fixed step per
//   cycle (up to MAX_STEPS) while out_stall is low; the back end takes no new
//   item until those steps end; front takes one item per cycle unless in_stall
// reset: synchronous rst_n clears sim clock, accumulator, queue and registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_fixed_step_timebase_core_assert.svh"

module scaled_fixed_step_timebase_core #(
  parameter int MAX_STEPS = sfst_pkg::MAX_STEPS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire [sfst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [sfst_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [sfst_pkg::REAL_W-1:0]          in_real_delta,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [sfst_pkg::TIME_W-1:0]  out_sim_time,
  output logic signed [sfst_pkg::LEN_W-1:0]   out_step_length,
  output logic                                out_advanced,
  output logic                                out_last
);

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_valid;
  sfst_pkg::item_t       q_wr_item;
  sfst_pkg::item_t       q_rd_item;
  sfst_pkg::back_cfg_t   bcfg;

  sfst_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_real_delta (in_real_delta),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_wr_item),
    .bcfg          (bcfg)
  );

  sfst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_item  (q_wr_item),
    .pop      (q_pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  sfst_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_rd_item),
    .q_pop           (q_pop),
    .bcfg            (bcfg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sim_time    (out_sim_time),
    .out_step_length (out_step_length),
    .out_advanced    (out_advanced),
    .out_last        (out_last)
  );

  `SFST_ASSERT_IMPL(a_hold_item, out_valid && !out_advanced, out_last && out_step_length == 0, "hold item not a single zero-length result")
  `SFST_ASSERT_IMPL(a_step_nonzero, out_valid && out_advanced && !out_last, out_step_length != 0, "fixed step of zero length")
  `SFST_ASSERT_NEXT(a_step_burst, out_valid && !out_last && !out_stall, out_valid, "gap inside a fixed-step burst")

endmodule

`default_nettype wire

// File: rtl/sfst_front.sv
// ----------------------------------------------------------------------------
// sfst_front
// register file, item classification and scaled delta (split multiply)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfst_front (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [sfst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [sfst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [sfst_pkg::REAL_W-1:0]         in_real_delta,
  input  wire                                q_full,
  output logic                               q_push,
  output sfst_pkg::item_t                    q_item,
  output sfst_pkg::back_cfg_t                bcfg
);

  logic                                   paused_r;
  logic                                   allow_neg_r;
  logic                                   mode_r;
  logic signed [sfst_pkg::SCALE_W-1:0]    scale_r;
  logic [sfst_pkg::STEP_W-1:0]            step_r;
  logic                                   acc_clr_r;

  logic signed [sfst_pkg::SCALE_W-1:0]    wr_scale;
  logic signed [sfst_pkg::SCALE_W-1:0]    scale_lo;
  logic signed [sfst_pkg::SCALE_W-1:0]    scale_clamped;
  logic [sfst_pkg::STEP_W-1:0]            wr_step;
  logic [sfst_pkg::STEP_W-1:0]            step_clamped;

  logic                                   s1_v_r;
  logic                                   s1_v_nxt;
  logic [1:0]                             s1_kind_r;
  logic signed [sfst_pkg::PP_W-1:0]       pp_lo_r;
  logic signed [sfst_pkg::PP_W-1:0]       pp_hi_r;
  logic signed [sfst_pkg::HALF_W:0]       op_lo;
  logic signed [sfst_pkg::HALF_W:0]       op_hi;
  logic signed [sfst_pkg::PP_W-1:0]       pp_lo;
  logic signed [sfst_pkg::PP_W-1:0]       pp_hi;
  logic [1:0]                             kind;
  logic                                   accept;
  logic signed [sfst_pkg::TIME_W-1:0]     prod;

  // write-side clamps
  always_comb begin
    wr_scale = $signed(cfg_wdata[sfst_pkg::SCALE_W-1:0]);
    scale_lo = allow_neg_r ? -sfst_pkg::SCALE_LIMIT : '0;
    if (wr_scale < scale_lo) begin
      scale_clamped = scale_lo;
    end else if (wr_scale > sfst_pkg::SCALE_LIMIT) begin
      scale_clamped = sfst_pkg::SCALE_LIMIT;
    end else begin
      scale_clamped = wr_scale;
    end
    wr_step = cfg_wdata[sfst_pkg::STEP_W-1:0];
    if (wr_step < sfst_pkg::STEP_MIN) begin
      step_clamped = sfst_pkg::STEP_MIN;
    end else if (wr_step > sfst_pkg::STEP_MAX) begin
      step_clamped = sfst_pkg::STEP_MAX;
    end else begin
      step_clamped = wr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r    <= 1'b0;
      allow_neg_r <= 1'b0;
      mode_r      <= 1'b0;
      scale_r     <= sfst_pkg::SCALE_RESET;
      step_r      <= sfst_pkg::STEP_RESET;
      acc_clr_r   <= 1'b0;
    end else begin
      acc_clr_r <= cfg_we && (cfg_index == sfst_pkg::REG_CLOCK_MODE);
      if (cfg_we) begin
        case (cfg_index)
          sfst_pkg::REG_PAUSED: begin
            paused_r <= cfg_wdata[0];
          end
          sfst_pkg::REG_ALLOW_NEG: begin
            allow_neg_r <= cfg_wdata[0];
            if (!cfg_wdata[0] && scale_r < 0) begin
              scale_r <= '0;
            end
          end
          sfst_pkg::REG_CLOCK_MODE: begin
            mode_r <= cfg_wdata[0];
          end
          sfst_pkg::REG_TIME_SCALE: begin
            scale_r <= scale_clamped;
          end
          sfst_pkg::REG_FIXED_STEP: begin
            step_r <= step_clamped;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // classify and form the two partial products
  always_comb begin
    in_stall = s1_v_r && q_full;
    accept   = in_valid && !in_stall;
    q_push   = s1_v_r && !q_full;
    s1_v_nxt = (s1_v_r && q_full) || accept;
    op_lo    = $signed({1'b0, in_real_delta[sfst_pkg::HALF_W-1:0]});
    op_hi    = $signed({1'b0, in_real_delta[sfst_pkg::REAL_W-1:sfst_pkg::HALF_W]});
    pp_lo    = op_lo * scale_r;
    pp_hi    = op_hi * scale_r;
    if (paused_r || scale_r == 0) begin
      kind = sfst_pkg::KIND_HOLD;
    end else if (mode_r) begin
      kind = sfst_pkg::KIND_FIXED;
    end else begin
      kind = sfst_pkg::KIND_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= kind;
      pp_lo_r   <= pp_lo;
      pp_hi_r   <= pp_hi;
    end
  end

  // floor(real * scale / 2^16) by arithmetic shift
  always_comb begin
    prod = $signed({pp_hi_r, {sfst_pkg::HALF_W{1'b0}}})
         + $signed({{(sfst_pkg::TIME_W - sfst_pkg::PP_W){pp_lo_r[sfst_pkg::PP_W-1]}},
                    pp_lo_r});
    q_item.kind      = s1_kind_r;
    q_item.delta     = prod[sfst_pkg::TIME_W-1:16];
    bcfg.fixed_step  = step_r;
    bcfg.acc_clr     = acc_clr_r;
  end

endmodule

`default_nettype wire

// File: rtl/sfst_queue.sv
// ----------------------------------------------------------------------------
// sfst_queue
// short item queue between the front and the stepping back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfst_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire sfst_pkg::item_t wr_item,
  input  wire                  pop,
  output logic                 full,
  output logic                 rd_valid,
  output sfst_pkg::item_t      rd_item
);

  sfst_pkg::item_t             mem_r [sfst_pkg::Q_DEPTH];
  logic [sfst_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [sfst_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [sfst_pkg::Q_AW:0]     cnt_r;

  always_comb begin
    full     = (cnt_r == (sfst_pkg::Q_AW + 1)'(sfst_pkg::Q_DEPTH));
    rd_valid = (cnt_r != '0);
    rd_item  = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sfst_back.sv
// ----------------------------------------------------------------------------
// sfst_back
// sim clock, step accumulator and fixed-step sequencer with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfst_back #(
  parameter int MAX_STEPS = sfst_pkg::MAX_STEPS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 q_valid,
  input  wire sfst_pkg::item_t                q_item,
  output logic                                q_pop,
  input  wire sfst_pkg::back_cfg_t            bcfg,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [sfst_pkg::TIME_W-1:0]  out_sim_time,
  output logic signed [sfst_pkg::LEN_W-1:0]   out_step_length,
  output logic                                out_advanced,
  output logic                                out_last
);

  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_STEPS);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_STEP = 1'b1;

  logic                                 state_r;
  logic                                 state_nxt;
  logic signed [sfst_pkg::TIME_W-1:0]   acc_r;
  logic signed [sfst_pkg::TIME_W-1:0]   acc_nxt;
  logic [sfst_pkg::TIME_W-1:0]          clk_r;
  logic [sfst_pkg::TIME_W-1:0]          clk_nxt;
  logic [CNT_W-1:0]                     n_r;
  logic [CNT_W-1:0]                     n_nxt;
  logic [CNT_W-1:0]                     n_inc;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;

  logic signed [sfst_pkg::TIME_W-1:0]   fs;
  logic signed [sfst_pkg::TIME_W-1:0]   fs2;
  logic signed [sfst_pkg::TIME_W-1:0]   step_len;
  logic signed [sfst_pkg::TIME_W-1:0]   acc_step;
  logic [sfst_pkg::TIME_W-1:0]          clk_step;
  logic signed [sfst_pkg::TIME_W-1:0]   delta_ext;
  logic                                 fwd;
  logic                                 fits;
  logic                                 fits2;
  logic                                 at_cap;
  logic                                 out_ld;
  logic                                 emit;
  logic                                 fin;
  logic [sfst_pkg::TIME_W-1:0]          e_time;
  logic signed [sfst_pkg::LEN_W-1:0]    e_len;
  logic                                 e_adv;
  logic                                 e_last;

  always_comb begin
    fs        = $signed({{(sfst_pkg::TIME_W - sfst_pkg::STEP_W){1'b0}}, bcfg.fixed_step});
    fs2       = $signed({{(sfst_pkg::TIME_W - sfst_pkg::STEP_W - 1){1'b0}},
                         bcfg.fixed_step, 1'b0});
    fwd       = !acc_r[sfst_pkg::TIME_W-1];
    fits      = fwd ? (acc_r >= fs) : (acc_r <= -fs);
    fits2     = fwd ? (acc_r >= fs2) : (acc_r <= -fs2);
    n_inc     = n_r + CNT_W'(1);
    at_cap    = (n_inc == CNT_CAP);
    step_len  = fwd ? fs : -fs;
    acc_step  = acc_r - step_len;
    clk_step  = clk_r + step_len;
    delta_ext = $signed({{(sfst_pkg::TIME_W - sfst_pkg::LEN_W){q_item.delta[sfst_pkg::LEN_W-1]}},
                         q_item.delta});
    out_ld    = !out_valid_r || !out_stall;
    q_pop     = (state_r == ST_IDLE) && q_valid && out_ld;

    state_nxt = state_r;
    acc_nxt   = acc_r;
    clk_nxt   = clk_r;
    n_nxt     = n_r;
    emit      = 1'b0;
    fin       = 1'b0;
    e_time    = clk_r;
    e_len     = '0;
    e_adv     = 1'b0;
    e_last    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_item.kind)
            sfst_pkg::KIND_HOLD: begin
              emit = 1'b1;
            end
            sfst_pkg::KIND_REAL: begin
              clk_nxt = clk_r + delta_ext;
              emit    = 1'b1;
              e_time  = clk_nxt;
              e_len   = q_item.delta;
              e_adv   = 1'b1;
            end
            sfst_pkg::KIND_FIXED: begin
              acc_nxt   = acc_r + delta_ext;
              n_nxt     = '0;
              state_nxt = ST_STEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_STEP: begin
        if (out_ld) begin
          if (fits) begin
            fin     = at_cap || !fits2;
            emit    = 1'b1;
            e_time  = clk_step;
            e_len   = step_len[sfst_pkg::LEN_W-1:0];
            e_adv   = 1'b1;
            e_last  = fin;
            clk_nxt = clk_step;
            acc_nxt = at_cap ? '0 : acc_step;
            n_nxt   = n_inc;
            if (fin) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // mode write clears the accumulator
    if (bcfg.acc_clr) begin
      acc_nxt = '0;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      clk_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      clk_r       <= clk_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sim_time    <= $signed(e_time);
      out_step_length <= e_len;
      out_advanced    <= e_adv;
      out_last        <= e_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives real-time ticks and register writes into the scaled fixed-step
// timebase, predicts each result from a local copy of the sim clock, the step
// accumulator and the registers, and checks results in order: a directed
// table first, then random register settings with bursts of ticks
// ----------------------------------------------------------------------------
module tb_top;
  import sfst_pkg::*;

  localparam int SETTLE_CYC = 12;
  localparam int RAND_ITEMS = 270;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [REAL_W-1:0] REAL_MAX = '1;
  localparam logic [REAL_W-1:0] ONE_SEC = 36'h1_0000_0000;

  typedef struct packed {
    logic signed [TIME_W-1:0] sim_time;
    logic signed [LEN_W-1:0]  step_len;
    logic                     adv;
    logic                     last;
  } tick_result_t;

  typedef enum logic {ROW_REG, ROW_TICK} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [REAL_W-1:0]      rd;
    bit                     known;
    tick_result_t           want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [REAL_W-1:0] in_real_delta;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TIME_W-1:0] out_sim_time;
  logic signed [LEN_W-1:0] out_step_length;
  logic out_advanced;
  logic out_last;

  // mirror of the block state
  bit m_paused;
  bit m_neg_ok;
  bit m_mode;
  logic signed [SCALE_W-1:0] m_scale;
  logic [STEP_W-1:0] m_step;
  logic [TIME_W-1:0] m_clock;
  logic signed [63:0] m_acc;

  tick_result_t due_results[$];
  int bad_results = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  int stall_hold = 0;

  scaled_fixed_step_timebase_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_real_delta  (in_real_delta),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sim_time   (out_sim_time),
    .out_step_length(out_step_length),
    .out_advanced   (out_advanced),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    int roll;
    if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
    if (stall_hold != 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if (calm_out) begin
      out_stall <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_stall <= 1'b0;
      end else if (roll < 96) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(5, 30);
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_sim_time, out_step_length, out_advanced, out_last};
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t unexpected result: sim_time %h step %h adv %b last %b",
                   $realtime, got.sim_time, got.step_len, got.adv, got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("%0t mismatch: exp sim_time %h step %h adv %b last %b",
                     $realtime, want.sim_time, want.step_len, want.adv, want.last);
            $display("%0t           got sim_time %h step %h adv %b last %b",
                     $realtime, got.sim_time, got.step_len, got.adv, got.last);
          end
        end
      end
    end
  end

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] d);
    plan_row_t r;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = d;
    r.rd = '0;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic [REAL_W-1:0] rd);
    plan_row_t r;
    r = reg_row(REG_PAUSED, '0);
    r.kind = ROW_TICK;
    r.rd = rd;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [REAL_W-1:0] rd,
                                          input logic [TIME_W-1:0] t,
                                          input logic [LEN_W-1:0] len,
                                          input logic adv);
    plan_row_t r;
    r = tick_row(rd);
    r.known = 1'b1;
    r.want.sim_time = t;
    r.want.step_len = len;
    r.want.adv = adv;
    r.want.last = 1'b1;
    return r;
  endfunction

  task automatic mirror_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] d);
    logic [STEP_W-1:0] v;
    case (idx)
      REG_PAUSED:     m_paused = d[0];
      REG_ALLOW_NEG:  m_neg_ok = d[0];
      REG_CLOCK_MODE: begin
        m_mode = d[0];
        m_acc = '0;
      end
      REG_TIME_SCALE: m_scale = $signed(d[SCALE_W-1:0]);
      REG_FIXED_STEP: begin
        v = d[STEP_W-1:0];
        if (v < STEP_MIN) v = STEP_MIN;
        if (v > STEP_MAX) v = STEP_MAX;
        m_step = v;
      end
      default: ;
    endcase
    if (idx == REG_ALLOW_NEG || idx == REG_TIME_SCALE) begin
      if (!m_neg_ok && m_scale < 0) m_scale = '0;
      if (m_scale < -SCALE_LIMIT) m_scale = -SCALE_LIMIT;
      if (m_scale > SCALE_LIMIT) m_scale = SCALE_LIMIT;
    end
  endtask

  // works out the results of one tick and advances the mirror
  task automatic advance_timebase(input logic [REAL_W-1:0] rd, input bit keep);
    logic [63:0] prod;
    logic [SCALE_W-1:0] mag;
    logic signed [63:0] delta;
    logic signed [63:0] span;
    logic [63:0] quot;
    int reps;
    bit fwd;
    tick_result_t r;
    r.sim_time = m_clock;
    r.step_len = '0;
    r.adv = 1'b0;
    r.last = 1'b1;
    if (m_paused || m_scale == 0) begin
      if (keep) due_results.push_back(r);
      return;
    end
    mag = m_scale[SCALE_W-1] ? SCALE_W'(-m_scale) : SCALE_W'(m_scale);
    prod = {28'd0, rd} * {37'd0, mag};
    if (!m_scale[SCALE_W-1]) delta = $signed(prod >> 16);
    else delta = -$signed((prod + 64'd65535) >> 16);
    if (!m_mode) begin
      m_clock = m_clock + 64'(delta);
      r.sim_time = m_clock;
      r.step_len = delta[LEN_W-1:0];
      r.adv = 1'b1;
      if (keep) due_results.push_back(r);
      return;
    end
    m_acc = m_acc + delta;
    span = $signed({31'd0, m_step});
    fwd = (m_acc >= 0);
    quot = fwd ? 64'(m_acc / span) : 64'((-m_acc) / span);
    reps = (quot > 64'(MAX_STEPS_DEF)) ? MAX_STEPS_DEF : int'(quot);
    for (int k = 0; k < reps; k++) begin
      if (fwd) begin
        m_clock = m_clock + 64'(span);
        m_acc = m_acc - span;
        r.step_len = span[LEN_W-1:0];
      end else begin
        m_clock = m_clock - 64'(span);
        m_acc = m_acc + span;
        r.step_len = LEN_W'(-span);
      end
      r.sim_time = m_clock;
      r.adv = 1'b1;
      r.last = (k == reps - 1);
      if (keep) due_results.push_back(r);
    end
    if (reps == MAX_STEPS_DEF) m_acc = '0;
  endtask

  task automatic post_tick(input logic [REAL_W-1:0] rd, input bit keep);
    int roll;
    int gap;
    if ($urandom_range(0, 99) < 5) calm_in = !calm_in;
    roll = $urandom_range(0, 99);
    if (calm_in || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 8);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_real_delta <= rd;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    advance_timebase(rd, keep);
  endtask

  // stop sending and let everything in flight drain
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_reg_write(idx, d);
  endtask

  initial begin
    plan_row_t plan[$];
    int done;
    int burst;
    int roll;
    logic [CFG_DATA_W-1:0] d;
    logic signed [SCALE_W-1:0] s;
    logic [SCALE_W-1:0] mag;
    logic [63:0] want;
    logic [63:0] rdw;
    logic [REAL_W-1:0] rd;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_real_delta = '0;
    m_paused = 1'b0;
    m_neg_ok = 1'b0;
    m_mode = 1'b0;
    m_scale = SCALE_RESET;
    m_step = STEP_RESET;
    m_clock = '0;
    m_acc = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // real-time mode, holds and scale clamping
    plan.push_back(known_row(ONE_SEC, 64'h1_0000_0000, 48'h1_0000_0000, 1'b1));
    plan.push_back(known_row(36'd0, 64'h1_0000_0000, 48'd0, 1'b1));
    plan.push_back(tick_row(REAL_MAX));
    plan.push_back(reg_row(REG_PAUSED, 33'h1_FFFF_FFFF));
    plan.push_back(known_row(ONE_SEC, 64'h10_FFFF_FFFF, 48'd0, 1'b0));
    plan.push_back(reg_row(REG_PAUSED, 33'h1_FFFF_FFFE));
    plan.push_back(reg_row(REG_TIME_SCALE, 33'd0));
    plan.push_back(known_row(36'h1234_5678, 64'h10_FFFF_FFFF, 48'd0, 1'b0));
    plan.push_back(reg_row(REG_TIME_SCALE, 33'h0_0400_0000));
    plan.push_back(known_row(REAL_MAX, 64'h10_FFFF_FFFF, 48'd0, 1'b0));
    plan.push_back(reg_row(REG_ALLOW_NEG, 33'h1_FFFF_FFFF));
    plan.push_back(reg_row(REG_TIME_SCALE, 33'h0_0400_0000));
    plan.push_back(tick_row(REAL_MAX));
    plan.push_back(reg_row(REG_TIME_SCALE, 33'h0_07FF_FFFF));
    plan.push_back(tick_row(36'd1));
    plan.push_back(reg_row(REG_TIME_SCALE, 33'h1_03E8_0001));
    plan.push_back(tick_row(REAL_MAX));
    plan.push_back(reg_row(REG_TIME_SCALE, 33'h0_07FF_0000));
    plan.push_back(reg_row(REG_ALLOW_NEG, 33'd0));
    plan.push_back(tick_row(36'h8_0000_0000));
    // fixed-step mode: cap, no step, backward steps, ignored index
    plan.push_back(reg_row(REG_TIME_SCALE, 33'd65536));
    plan.push_back(reg_row(REG_CLOCK_MODE, 33'd1));
    plan.push_back(reg_row(REG_FIXED_STEP, 33'd0));
    plan.push_back(tick_row(36'd143165576));
    plan.push_back(tick_row(36'd17895696));
    plan.push_back(tick_row(36'd1));
    plan.push_back(reg_row(REG_FIXED_STEP, 33'h1_FFFF_FFFF));
    plan.push_back(tick_row(REAL_MAX));
    plan.push_back(reg_row(REG_ALLOW_NEG, 33'd1));
    plan.push_back(reg_row(REG_TIME_SCALE, 33'h0_07FF_0000));
    plan.push_back(tick_row(36'h1_0000_0005));
    plan.push_back(reg_row(REG_UNUSED, 33'h1_5555_5555));
    plan.push_back(tick_row(ONE_SEC));
    plan.push_back(reg_row(REG_CLOCK_MODE, 33'd1));
    plan.push_back(tick_row(36'd0));
    plan.push_back(reg_row(REG_PAUSED, 33'd1));
    plan.push_back(tick_row(36'h3_0000_0000));
    plan.push_back(reg_row(REG_PAUSED, 33'd0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        post_tick(plan[i].rd, !plan[i].known);
        if (plan[i].known) due_results.push_back(plan[i].want);
      end
    end

    done = 0;
    while (done < RAND_ITEMS) begin
      // new register setting for this burst
      if ($urandom_range(0, 1)) begin
        d = {32'($urandom), 1'b0};
        d[0] = ($urandom_range(0, 99) < 15);
        write_reg(REG_PAUSED, d);
      end
      if ($urandom_range(0, 1)) write_reg(REG_ALLOW_NEG, 33'($urandom_range(0, 7)));
      if ($urandom_range(0, 99) < 60) begin
        d = {32'($urandom), 1'b0};
        d[0] = ($urandom_range(0, 99) < 65);
        write_reg(REG_CLOCK_MODE, d);
      end
      if ($urandom_range(0, 99) < 70) begin
        roll = $urandom_range(0, 9);
        case (roll)
          0: s = SCALE_LIMIT;
          1: s = -SCALE_LIMIT;
          2: s = '0;
          default: begin
            s = SCALE_W'($urandom_range(1, 4 * 65536));
            if ($urandom_range(0, 1)) s = -s;
          end
        endcase
        d = {6'($urandom), s};
        if (roll == 3) d = {1'($urandom), 32'($urandom)};
        write_reg(REG_TIME_SCALE, d);
      end
      if ($urandom_range(0, 99) < 60) begin
        case ($urandom_range(0, 9))
          0: d = STEP_MIN;
          1: d = STEP_MAX;
          2: d = '0;
          3: d = 33'h1_FFFF_FFFF;
          4: d = {1'($urandom), 32'($urandom)};
          default: d = 33'($urandom_range(STEP_MIN, 32'd429496730));
        endcase
        write_reg(REG_FIXED_STEP, d);
      end
      if ($urandom_range(0, 99) < 10)
        write_reg(CFG_IDX_W'(REG_FIXED_STEP + $urandom_range(1, 3)),
                  {1'($urandom), 32'($urandom)});

      burst = $urandom_range(10, 30);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 4) wait_quiet();
        if (m_mode && m_scale != 0 && $urandom_range(0, 99) < 80) begin
          // aim at a whole number of steps plus a remainder
          want = 64'($urandom_range(0, 9)) * {31'd0, m_step}
               + 64'($urandom_range(0, 32'(m_step - 33'd1)));
          mag = m_scale[SCALE_W-1] ? SCALE_W'(-m_scale) : SCALE_W'(m_scale);
          rdw = (want << 16) / {37'd0, mag};
          rd = (rdw > 64'(REAL_MAX)) ? REAL_MAX : rdw[REAL_W-1:0];
        end else if ($urandom_range(0, 99) < 70) begin
          rd = REAL_W'($urandom_range(0, 32'd1073741824));
        end else begin
          rd = {4'($urandom), 32'($urandom)};
        end
        post_tick(rd, 1'b1);
        done++;
      end
    end

    wait_quiet();
    if (bad_results == 0) begin
      $display("PASS scaled_fixed_step_timebase_core");
    end else begin
      $display("FAIL scaled_fixed_step_timebase_core");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL scaled_fixed_step_timebase_core");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sfst_pkg.sv
rtl/sfst_front.sv
rtl/sfst_queue.sv
rtl/sfst_back.sv
rtl/scaled_fixed_step_timebase_core.sv
tb/sv/tb_top.sv
